// ===== design/command_record_packetizer_core_defines.svh =====
// assertion macros for the checker file of the packetizer core
// no dependencies; each macro expects clk_i and rst_ni in scope
`ifndef COMMAND_RECORD_PACKETIZER_CORE_DEFINES_SVH
`define COMMAND_RECORD_PACKETIZER_CORE_DEFINES_SVH

// property checked while out of reset
`define CRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at edges that see reset asserted
`define CRP_ASSERT_IN_RST(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) !rst_ni |-> (expr)) else $error(msg);

`endif

// ===== design/crp_pkg.sv =====
// package of the command record packetizer: sizes, byte codes, types
// used by the controller, datapath, top level and checker of the packetizer core
package crp_pkg;

  localparam int PacketBytes = 64;
  localparam int HeaderBytes = 4;
  localparam int PadCap      = 64;

  localparam logic [7:0] SyncByte0    = 8'hFD;
  localparam logic [7:0] SyncByte1    = 8'hB2;
  localparam logic [7:0] ZeroByte     = 8'h00;
  localparam logic [7:0] PadByte      = 8'hFF;
  localparam logic [7:0] TagReadWait  = 8'h80;
  localparam logic [7:0] TagWriteWait = 8'hC0;

  typedef enum logic [1:0] {
    OpBlockWrite = 2'd0,
    OpReadWait   = 2'd1,
    OpWriteWait  = 2'd2,
    OpFlush      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StFlush,
    StSend,
    StWrite
  } state_e;

  typedef enum logic [2:0] {
    KindSync0,
    KindSync1,
    KindZero,
    KindStore,
    KindPad
  } kind_e;

  typedef struct packed {
    logic load_rec;
    logic emit_issue;
    logic fill_reset;
    logic write_byte;
  } crp_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic overflow;
    logic pending;
    logic out_free;
    logic emit_last;
    logic write_last;
  } crp_stat_t;

endpackage

// ===== design/crp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/crp_ctrl.sv =====
// controller of the packetizer: idle, flush, send and record write sequencing
// depends on crp_pkg
module crp_ctrl import crp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  crp_stat_t stat_i,
  output crp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_rec = 1'b1;
          if (stat_i.is_flush) begin
            if (stat_i.pending) begin
              state_d = StFlush;
            end
          end else if (stat_i.overflow && stat_i.pending) begin
            state_d = StSend;
          end else begin
            state_d = StWrite;
          end
        end
      end
      StFlush, StSend: begin
        cmd_o.emit_issue = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          cmd_o.fill_reset = 1'b1;
          state_d = (state_q == StSend) ? StWrite : StIdle;
        end
      end
      StWrite: begin
        cmd_o.write_byte = 1'b1;
        if (stat_i.write_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== design/crp_datapath.sv =====
// datapath of the packetizer: record build, fill count, packet store, output stage
// depends on crp_pkg and crp_ram
module crp_datapath import crp_pkg::*; #(
  parameter int PACKET_BYTES = PacketBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] op_i,
  input  logic [1:0] port_i,
  input  logic [2:0] count_i,
  input  logic [7:0] data0_i,
  input  logic [7:0] data1_i,
  input  logic [7:0] data2_i,
  input  logic [7:0] data3_i,
  input  logic [7:0] wait_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  input  crp_cmd_t   cmd_i,
  output crp_stat_t  stat_o
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int FW = $clog2(PACKET_BYTES + 1);
  localparam int CW = $clog2(PACKET_BYTES + 3);

  logic [FW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    wr_idx_q, wr_idx_d;
  logic [2:0]    len_q;
  logic [7:0]    rec_q [5];
  logic          valid_q, valid_d;
  kind_e         kind_q, kind_d;
  logic          last_q;

  logic [2:0]    cnt;
  logic [2:0]    cnt_m1;
  logic [2:0]    len_in;
  logic [7:0]    tag_in;
  logic [1:0]    pads;
  logic [CW-1:0] total;
  logic          emit_last;
  logic          rd_en;
  logic [7:0]    rd_data;

  // record build from the input fields
  always_comb begin
    if (count_i == 3'd0) begin
      cnt = 3'd1;
    end else if (count_i > 3'd4) begin
      cnt = 3'd4;
    end else begin
      cnt = count_i;
    end
    cnt_m1 = cnt - 3'd1;
    if (op_i == OpBlockWrite) begin
      tag_in = {2'b00, cnt_m1[1:0], 2'b00, port_i};
      len_in = cnt + 3'd1;
    end else begin
      tag_in = ((op_i == OpReadWait) ? TagReadWait : TagWriteWait) | {6'd0, port_i};
      len_in = 3'd2;
    end
  end

  // packet length with pad bytes
  always_comb begin
    if (int'(fill_q) >= PadCap) begin
      pads = 2'd0;
    end else if (int'(fill_q) == PadCap - 1) begin
      pads = 2'd1;
    end else begin
      pads = 2'd2;
    end
    total     = CW'(fill_q) + CW'(pads);
    emit_last = (idx_q == total - CW'(1));
  end

  always_comb begin
    if (idx_q < CW'(HeaderBytes)) begin
      unique case (idx_q[1:0])
        2'd0:    kind_d = KindSync0;
        2'd1:    kind_d = KindSync1;
        default: kind_d = KindZero;
      endcase
    end else if (idx_q < CW'(fill_q)) begin
      kind_d = KindStore;
    end else begin
      kind_d = KindPad;
    end
  end

  assign rd_en = cmd_i.emit_issue && (kind_d == KindStore);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_reset) begin
      fill_d = FW'(HeaderBytes);
    end else if (cmd_i.write_byte) begin
      fill_d = fill_q + FW'(1);
    end

    idx_d = idx_q;
    if (cmd_i.load_rec) begin
      idx_d = '0;
    end else if (cmd_i.emit_issue) begin
      idx_d = idx_q + CW'(1);
    end

    wr_idx_d = wr_idx_q;
    if (cmd_i.load_rec) begin
      wr_idx_d = 3'd0;
    end else if (cmd_i.write_byte) begin
      wr_idx_d = wr_idx_q + 3'd1;
    end

    valid_d = valid_q;
    if (cmd_i.emit_issue) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= FW'(HeaderBytes);
      idx_q    <= '0;
      wr_idx_q <= 3'd0;
      valid_q  <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      wr_idx_q <= wr_idx_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rec) begin
      len_q    <= len_in;
      rec_q[0] <= tag_in;
      if (op_i == OpBlockWrite) begin
        rec_q[1] <= data0_i;
      end else begin
        rec_q[1] <= wait_value_i;
      end
      rec_q[2] <= data1_i;
      rec_q[3] <= data2_i;
      rec_q[4] <= data3_i;
    end
    if (cmd_i.emit_issue) begin
      kind_q <= kind_d;
      last_q <= emit_last;
    end
  end

  crp_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_byte),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rec_q[wr_idx_q]),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    unique case (kind_q)
      KindSync0: out_byte_o = SyncByte0;
      KindSync1: out_byte_o = SyncByte1;
      KindZero:  out_byte_o = ZeroByte;
      KindStore: out_byte_o = rd_data;
      KindPad:   out_byte_o = PadByte;
      default:   out_byte_o = ZeroByte;
    endcase
  end

  assign out_valid_o = valid_q;
  assign last_o      = last_q;

  assign stat_o.is_flush   = (op_i == OpFlush);
  assign stat_o.overflow   = ({1'b0, fill_q} + (FW + 1)'(len_in)) > (FW + 1)'(PACKET_BYTES);
  assign stat_o.pending    = fill_q > FW'(HeaderBytes);
  assign stat_o.out_free   = !valid_q || !out_stall_i;
  assign stat_o.emit_last  = emit_last;
  assign stat_o.write_last = (wr_idx_q == len_q - 3'd1);

endmodule

// ===== design/command_record_packetizer_core.sv =====
// top level of the command record packetizer: controller plus datapath
// depends on crp_pkg, crp_ctrl, crp_datapath
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid_i/in_stall_o | op, port, count, data0..3, wait_value
//   out     | output    | out_valid_o/out_stall_i | out_byte, last
//
// a record is accepted, then its bytes (2 to 5) are written into the store
// a send streams one byte per cycle while out is not stalled, header, records, pads
// a record that overflows the packet waits for its send to be issued before its write
// the store ram has one write port, so record bytes go in one per cycle
// rst_ni clears the fill count to the header size and empties the output stage
// a stalled output beat holds; the block takes a new item while a final beat waits
module command_record_packetizer_core import crp_pkg::*; #(
  parameter int PACKET_BYTES = PacketBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [1:0] port_i,
  input  logic [2:0] count_i,
  input  logic [7:0] data0_i,
  input  logic [7:0] data1_i,
  input  logic [7:0] data2_i,
  input  logic [7:0] data3_i,
  input  logic [7:0] wait_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  crp_cmd_t  cmd;
  crp_stat_t stat;

  crp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crp_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .port_i       (port_i),
    .count_i      (count_i),
    .data0_i      (data0_i),
    .data1_i      (data1_i),
    .data2_i      (data2_i),
    .data3_i      (data3_i),
    .wait_value_i (wait_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

// ===== design/crp_checker.sv =====
// port-level checker of the packetizer core, bound to the top level
// depends on crp_pkg and command_record_packetizer_core_defines.svh
`include "command_record_packetizer_core_defines.svh"

module crp_checker import crp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] op_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  logic       in_fire;
  logic       out_fire;
  logic       out_wait;
  logic [8:0] beat;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign out_wait = out_valid_o && out_stall_i;
  assign beat     = {out_byte_o, last_o};

  `CRP_ASSERT_IN_RST(a_rst_no_out, !out_valid_o, "output beat during reset")
  `CRP_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(beat), "stalled output beat changed")
  `CRP_ASSERT(a_new_packet, out_fire && last_o |=> !out_valid_o || (out_byte_o == SyncByte0), "packet does not open with the header")
  `CRP_ASSERT(a_mid_packet_stall, out_valid_o && !last_o |-> in_stall_o, "input open mid packet")
  `CRP_ASSERT(a_record_busy, in_fire && (op_i != OpFlush) |=> in_stall_o, "input open after a record")

endmodule

bind command_record_packetizer_core crp_checker u_crp_checker (.*);
